### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/cgth_pkg.sv
// ----------------------------------------------------------------------------
// cgth_pkg
// Shared constants, register map and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cgth_pkg;

	// defaults for top-level parameters
	localparam int MAX_BINS_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 32;

	// command codes on the request
	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_HIGH = 3'd6;

	// register reset values
	localparam logic [10:0]        RST_NUM_BINS = 11'd1024;
	localparam logic signed [20:0] RST_HIST_MIN = 21'sd0;
	localparam logic signed [20:0] RST_HIST_MAX = 21'sd640000;
	localparam logic [16:0]        RST_LOW_THR  = 17'd0;
	localparam logic [16:0]        RST_HIGH_THR = 17'd65536;
	localparam logic [14:0]        RST_SUM_LOW  = 15'd950;
	localparam logic [14:0]        RST_SUM_HIGH = 15'd1090;

	// energy calibration, Q.16 keV
	localparam int E_W = 33;
	localparam logic [31:0] CAL_A_GAIN = 32'd7804;
	localparam logic [31:0] CAL_B_GAIN = 32'd7582;
	localparam logic signed [E_W-1:0] CAL_OFS = 33'sd3093299;  // 1238630 + 1854669

	// time scaled by 17: D = (q - 11250) * 200, edges * 17
	localparam int T_W = 28;
	localparam int D_W = 26;
	localparam logic signed [T_W-1:0] T_OFS   = 28'sd11250;
	localparam logic signed [T_W-1:0] T_SCALE = 28'sd200;
	localparam logic signed [T_W-1:0] T_DEN   = 28'sd17;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic gate;
		logic mul;
		logic div_step;
		logic bin_load;
		logic rd_rb;
		logic ev_wr;
		logic res_rd;
		logic res_zero;
		logic clr_step;
	} cgth_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pass;
		logic edge_bin;
		logic clr_last;
	} cgth_stat_t;

endpackage

### hdl/cgth_ram.sv
// ----------------------------------------------------------------------------
// cgth_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cgth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/cgth_dp.sv
// ----------------------------------------------------------------------------
// cgth_dp
// Datapath: config registers, gates, binning divider, histogram store.
// ----------------------------------------------------------------------------
module cgth_dp import cgth_pkg::*; #(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]           charge_a,
	input  logic [15:0]           charge_b,
	input  logic [15:0]           charge_time,
	input  logic [10:0]           read_bin,
	input  cgth_cmd_t             cmd,
	output cgth_stat_t            stat,
	output logic                  accepted,
	output logic [10:0]           bin_index,
	output logic [31:0]           bin_count
);

	localparam int STORE_DEPTH = MAX_BINS + 2;
	localparam int BIN_W       = $clog2(STORE_DEPTH);
	localparam int NB_W        = $clog2(MAX_BINS + 1);
	localparam int P_W         = NB_W + D_W;

	// configuration
	logic [10:0]        num_bins_q;
	logic signed [20:0] hist_min_q;
	logic signed [20:0] hist_max_q;
	logic [16:0]        low_thr_q;
	logic [16:0]        high_thr_q;
	logic [14:0]        sum_low_q;
	logic [14:0]        sum_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= RST_NUM_BINS;
			hist_min_q <= RST_HIST_MIN;
			hist_max_q <= RST_HIST_MAX;
			low_thr_q  <= RST_LOW_THR;
			high_thr_q <= RST_HIGH_THR;
			sum_low_q  <= RST_SUM_LOW;
			sum_high_q <= RST_SUM_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_BINS: num_bins_q <= cfg_data[10:0];
				REG_HIST_MIN: hist_min_q <= cfg_data[20:0];
				REG_HIST_MAX: hist_max_q <= cfg_data[20:0];
				REG_LOW_THR:  low_thr_q  <= cfg_data[16:0];
				REG_HIGH_THR: high_thr_q <= cfg_data[16:0];
				REG_SUM_LOW:  sum_low_q  <= cfg_data[14:0];
				REG_SUM_HIGH: sum_high_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// active bin count, clamped to 1..MAX_BINS
	logic [31:0]     nb_ext;
	logic [NB_W-1:0] n_w;

	assign nb_ext = {21'b0, num_bins_q};
	assign n_w = (num_bins_q == 11'd0) ? NB_W'(1) :
		(nb_ext > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(num_bins_q);

	// request latch
	logic [15:0] qa_q, qb_q, qt_q;
	logic [10:0] rb_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qa_q <= charge_a;
			qb_q <= charge_b;
			qt_q <= charge_time;
			rb_q <= read_bin;
		end
	end

	// energy sum and scaled time
	logic [31:0]           pa_w, pb_w;
	logic signed [E_W-1:0] esum_w;
	logic signed [T_W-1:0] tdiff_w;
	logic signed [E_W-1:0] esum_q;
	logic signed [T_W-1:0] d_q, lo_q, hi_q;

	assign pa_w    = {16'b0, qa_q} * CAL_A_GAIN;
	assign pb_w    = {16'b0, qb_q} * CAL_B_GAIN;
	assign esum_w  = $signed({1'b0, pa_w + pb_w}) - CAL_OFS;
	assign tdiff_w = $signed({12'b0, qt_q}) - T_OFS;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			esum_q <= esum_w;
			d_q    <= tdiff_w * T_SCALE;
			lo_q   <= T_W'(hist_min_q) * T_DEN;
			hi_q   <= T_W'(hist_max_q) * T_DEN;
		end
	end

	// gates and range sort
	logic                  e_ok, t_ok, under_w, over_w;
	logic signed [T_W-1:0] diff_w, span_w;
	logic [D_W-1:0]        diff_q, span_q;
	logic [BIN_W-1:0]      bin_q;

	assign e_ok = (esum_q > $signed({2'b0, sum_low_q, 16'b0}))
		&& (esum_q < $signed({2'b0, sum_high_q, 16'b0}));
	assign t_ok = ({1'b0, qt_q} > low_thr_q) && ({1'b0, qt_q} < high_thr_q);
	assign under_w = d_q < lo_q;
	assign over_w  = d_q >= hi_q;
	assign diff_w  = d_q - lo_q;
	assign span_w  = hi_q - lo_q;

	assign stat.pass     = e_ok && t_ok;
	assign stat.edge_bin = under_w || over_w;

	// restoring divider, one quotient bit per cycle
	logic [P_W-1:0]  work_q;
	logic [D_W:0]    trial_w, nrem_w;
	logic            ge_w;
	logic [NB_W:0]   qsh_w;

	assign trial_w = {work_q[P_W-1:NB_W], work_q[NB_W-1]};
	assign ge_w    = trial_w >= {1'b0, span_q};
	assign nrem_w  = ge_w ? (trial_w - {1'b0, span_q}) : trial_w;
	assign qsh_w   = {work_q[NB_W-1:0], ge_w};

	always_ff @(posedge clk) begin
		if (cmd.gate) begin
			diff_q <= diff_w[D_W-1:0];
			span_q <= span_w[D_W-1:0];
			bin_q  <= under_w ? '0 : (BIN_W'(n_w) + BIN_W'(1));
		end else if (cmd.bin_load) begin
			bin_q <= BIN_W'(work_q[NB_W-1:0]) + BIN_W'(1);
		end
		if (cmd.mul) begin
			work_q <= {{D_W{1'b0}}, n_w} * {{NB_W{1'b0}}, diff_q};
		end else if (cmd.div_step) begin
			work_q <= {nrem_w[D_W-1:0], qsh_w[NB_W-1:0]};
		end
	end

	// histogram store and clearing sweep
	logic [BIN_W-1:0]      clr_addr_q;
	logic [BIN_W+10:0]     rb_ext;
	logic [BIN_W-1:0]      raddr_w, waddr_w;
	logic [COUNT_BITS-1:0] rdata_w, wdata_w, inc_w;
	logic                  we_w, rb_in_range;

	assign stat.clr_last = clr_addr_q == BIN_W'(STORE_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + BIN_W'(1);
		end
	end

	assign rb_ext      = {{BIN_W{1'b0}}, rb_q};
	assign rb_in_range = {21'b0, rb_q} < 32'(STORE_DEPTH);
	assign raddr_w     = cmd.rd_rb ? rb_ext[BIN_W-1:0] : bin_q;
	assign inc_w       = (&rdata_w) ? rdata_w : rdata_w + COUNT_BITS'(1);
	assign we_w        = cmd.clr_step || cmd.ev_wr;
	assign waddr_w     = cmd.clr_step ? clr_addr_q : bin_q;
	assign wdata_w     = cmd.clr_step ? '0 : inc_w;

	cgth_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we_w),
		.waddr (waddr_w),
		.wdata (wdata_w),
		.raddr (raddr_w),
		.rdata (rdata_w)
	);

	// result registers
	logic [COUNT_BITS+31:0] inc_ext, rd_ext;
	logic [BIN_W+10:0]      bin_ext;

	assign inc_ext = {32'b0, inc_w};
	assign rd_ext  = {32'b0, rdata_w};
	assign bin_ext = {11'b0, bin_q};

	always_ff @(posedge clk) begin
		if (cmd.ev_wr) begin
			accepted  <= 1'b1;
			bin_index <= bin_ext[10:0];
			bin_count <= inc_ext[31:0];
		end else if (cmd.res_rd) begin
			accepted  <= 1'b0;
			bin_index <= rb_q;
			bin_count <= rb_in_range ? rd_ext[31:0] : 32'd0;
		end else if (cmd.res_zero) begin
			accepted  <= 1'b0;
			bin_index <= 11'd0;
			bin_count <= 32'd0;
		end
	end

endmodule

### hdl/cgth_ctrl.sv
// ----------------------------------------------------------------------------
// cgth_ctrl
// Controller FSM: sequences requests, divider steps and the clearing sweep.
// ----------------------------------------------------------------------------
module cgth_ctrl import cgth_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd_in,
	input  cgth_stat_t stat,
	output cgth_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	localparam int NB_W  = $clog2(MAX_BINS + 1);
	localparam int CNT_W = $clog2(NB_W + 1);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_CALC,
		ST_GATE,
		ST_MUL,
		ST_DIV,
		ST_BIN,
		ST_EVRD,
		ST_EVWR,
		ST_RDRQ,
		ST_RDOUT,
		ST_ZERO
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             clr_resp_q;
	logic             div_last;

	assign div_last = div_cnt_q == CNT_W'(NB_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			div_cnt_q  <= '0;
			clr_resp_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLR: begin
					if (stat.clr_last) begin
						state_q    <= ST_IDLE;
						done       <= clr_resp_q;
						clr_resp_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (cmd_in)
							CMD_EVENT: state_q <= ST_CALC;
							CMD_READ:  state_q <= ST_RDRQ;
							CMD_CLEAR: begin
								state_q    <= ST_CLR;
								clr_resp_q <= 1'b1;
							end
							default:   state_q <= ST_ZERO;
						endcase
					end
				end
				ST_CALC: state_q <= ST_GATE;
				ST_GATE: begin
					if (!stat.pass) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end else if (stat.edge_bin) begin
						state_q <= ST_EVRD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q   <= ST_DIV;
					div_cnt_q <= '0;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + CNT_W'(1);
					if (div_last) begin
						state_q <= ST_BIN;
					end
				end
				ST_BIN:  state_q <= ST_EVRD;
				ST_EVRD: state_q <= ST_EVWR;
				ST_EVWR, ST_RDOUT, ST_ZERO: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				ST_RDRQ: state_q <= ST_RDOUT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.calc     = state_q == ST_CALC;
		cmd.gate     = state_q == ST_GATE;
		cmd.mul      = state_q == ST_MUL;
		cmd.div_step = state_q == ST_DIV;
		cmd.bin_load = state_q == ST_BIN;
		cmd.rd_rb    = state_q == ST_RDRQ;
		cmd.ev_wr    = state_q == ST_EVWR;
		cmd.res_rd   = state_q == ST_RDOUT;
		cmd.clr_step = state_q == ST_CLR;
		cmd.res_zero = ((state_q == ST_GATE) && !stat.pass) || (state_q == ST_ZERO)
			|| ((state_q == ST_CLR) && stat.clr_last && clr_resp_q);
	end

	assign busy = state_q != ST_IDLE;

endmodule

### hdl/coincidence_gated_time_histogram.sv
// Event: latch, calc, gate, then store read and update; a regular bin runs the multiply,
//   one divider step per quotient bit and the bin load; a rejected event stops at the gate.
// Clear: a sweep writes one store entry per cycle over all MAX_BINS+2 entries, then done.
// One request at a time; a new start is taken at the edge that ends the done cycle.
// Reset: config to defaults, then a sweep zeroes all MAX_BINS+2 store entries, busy high.
// Results are a one-cycle done strobe; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// coincidence_gated_time_histogram
// Energy-window and threshold gated time histogram with saturating bins,
// bin read-back and clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coincidence_gated_time_histogram import cgth_pkg::*; #(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [15:0]           charge_a,
	input  logic [15:0]           charge_b,
	input  logic [15:0]           charge_time,
	input  logic [10:0]           read_bin,
	// result
	output logic                  done,
	output logic                  accepted,
	output logic [10:0]           bin_index,
	output logic [31:0]           bin_count
);

	cgth_cmd_t  dp_cmd;
	cgth_stat_t dp_stat;

	// controller: one request in flight, divider iteration count, clear sweep
	cgth_ctrl #(
		.MAX_BINS (MAX_BINS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd_in (cmd),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: config regs, energy/time gates, n*(D-lo)/span divider,
	// read-modify-write of the bin counter in the histogram RAM
	cgth_dp #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.charge_a    (charge_a),
		.charge_b    (charge_b),
		.charge_time (charge_time),
		.read_bin    (read_bin),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.accepted    (accepted),
		.bin_index   (bin_index),
		.bin_count   (bin_count)
	);

	// a taken request always occupies the block
	`ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
	// the result strobe ends the request
	`ASSERT_SAME(a_done_idle, done, !busy, "done while still busy")
	// a result only follows work in progress
	`ASSERT_SAME(a_done_after_busy, done, $past(busy), "done without a request in flight")
	// the bin counter update never overlaps the latch of a new request
	`ASSERT_SAME(a_wr_no_start, dp_cmd.ev_wr, !dp_cmd.load, "store update overlaps a new request")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for coincidence_gated_time_histogram. A short table of
// directed requests runs at reset settings, then randomized requests run
// under a series of register settings. Every result is compared against a
// hand-written value or an in-bench model of the gates, time binning, bin store.
// ----------------------------------------------------------------------------
module tb;
	import cgth_pkg::*;

	// the block leaves the fourth command code unused
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int NUM_STORE = MAX_BINS_DEF + 2;

	// energy calibration in Q.16 keV, offsets of both channels combined
	localparam longint GAIN_A     = 7804;
	localparam longint GAIN_B     = 7582;
	localparam longint E_OFFSET   = 3093299;
	localparam longint KEV_SCALE  = 65536;
	localparam longint E_TOP_KEV  = 15300;  // below top sum of two 16-bit charges
	// time T = (q - 11250) * 200 / 17, kept scaled by 17
	localparam longint TIME_ZERO  = 11250;
	localparam longint TIME_SCALE = 200;
	localparam longint TIME_DEN   = 17;

	localparam int RAND_PHASES    = 10;
	localparam int REQS_PER_PHASE = 115;
	localparam int SETTLE_CYCLES  = 24;
	localparam int MAX_REPORTS    = 60;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{REG_NUM_BINS, REG_HIST_MIN,
		REG_HIST_MAX, REG_LOW_THR, REG_HIGH_THR, REG_SUM_LOW, REG_SUM_HIGH};

	typedef struct {
		logic [1:0]  op;
		logic [15:0] qa;
		logic [15:0] qb;
		logic [15:0] qt;
		logic [10:0] rb;
	} hist_req_t;

	typedef struct {
		logic        acc;
		logic [10:0] idx;
		logic [31:0] cnt;
	} hist_result_t;

	typedef struct {
		logic [10:0]        nbins;
		logic signed [20:0] hmin;
		logic signed [20:0] hmax;
		logic [16:0]        lothr;
		logic [16:0]        hithr;
		logic [14:0]        sumlo;
		logic [14:0]        sumhi;
	} hist_cfg_t;

	// directed row: request, then a hand-written result where typed is set
	typedef struct {
		logic [1:0]  op;
		logic [15:0] qa;
		logic [15:0] qb;
		logic [15:0] qt;
		logic [10:0] rb;
		bit          typed;
		logic        w_acc;
		logic [10:0] w_idx;
		logic [31:0] w_cnt;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic [1:0]            cmd = CMD_EVENT;
	logic [15:0]           charge_a = '0;
	logic [15:0]           charge_b = '0;
	logic [15:0]           charge_time = '0;
	logic [10:0]           read_bin = '0;
	logic                  busy;
	logic                  done;
	logic                  accepted;
	logic [10:0]           bin_index;
	logic [31:0]           bin_count;

	coincidence_gated_time_histogram dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.charge_a    (charge_a),
		.charge_b    (charge_b),
		.charge_time (charge_time),
		.read_bin    (read_bin),
		.done        (done),
		.accepted    (accepted),
		.bin_index   (bin_index),
		.bin_count   (bin_count)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Histogram model: its own copy of the bin store and the registers.
	// ------------------------------------------------------------------
	logic [31:0]  bin_counts [NUM_STORE];
	hist_cfg_t    cur_cfg;
	hist_result_t pending_results [$];
	int           failures = 0;

	// a bin count of zero acts as one, anything past MAX_BINS_DEF as the maximum
	function automatic int bins_in_use();
		int n;
		n = int'(cur_cfg.nbins);
		if (n < 1)
			n = 1;
		if (n > MAX_BINS_DEF)
			n = MAX_BINS_DEF;
		return n;
	endfunction

	// exact binning on the time scaled by 17; empty range falls to under/overflow
	function automatic logic [10:0] locate_bin(logic [15:0] qt);
		longint n, d, lo, hi;
		n  = longint'(bins_in_use());
		d  = (longint'(qt) - TIME_ZERO) * TIME_SCALE;
		lo = longint'(cur_cfg.hmin) * TIME_DEN;
		hi = longint'(cur_cfg.hmax) * TIME_DEN;
		if (d < lo)
			return 11'd0;
		if (d >= hi)
			return 11'(n + 1);
		return 11'(1 + (n * (d - lo)) / (hi - lo));
	endfunction

	// applies one request to the model store and returns its result
	function automatic hist_result_t histogram_step(hist_req_t r);
		hist_result_t res;
		longint       energy;
		logic [10:0]  b;
		res = '{acc: 1'b0, idx: '0, cnt: '0};
		case (r.op)
			CMD_EVENT: begin
				energy = GAIN_A * longint'(r.qa) + GAIN_B * longint'(r.qb) - E_OFFSET;
				if (energy > longint'(cur_cfg.sumlo) * KEV_SCALE &&
						energy < longint'(cur_cfg.sumhi) * KEV_SCALE &&
						r.qt > cur_cfg.lothr && r.qt < cur_cfg.hithr) begin
					b = locate_bin(r.qt);
					if (bin_counts[b] != 32'hFFFF_FFFF)
						bin_counts[b] = bin_counts[b] + 32'd1;
					res.acc = 1'b1;
					res.idx = b;
					res.cnt = bin_counts[b];
				end
			end
			CMD_READ: begin
				res.idx = r.rb;
				if (int'(r.rb) < NUM_STORE)
					res.cnt = bin_counts[r.rb];
			end
			CMD_CLEAR: begin
				foreach (bin_counts[i])
					bin_counts[i] = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result check: done is a one-cycle strobe, compared to the oldest entry.
	// ------------------------------------------------------------------
	task automatic note_mismatch(string what, longint want_v, longint got_v);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	always @(posedge clk) begin : result_check
		hist_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: result with none expected, expected nothing, got %0d/%0d/%0d",
						$time, accepted, bin_index, bin_count);
			end else begin
				want = pending_results.pop_front();
				if (accepted !== want.acc)
					note_mismatch("accepted", want.acc, accepted);
				if (bin_index !== want.idx)
					note_mismatch("bin_index", want.idx, bin_index);
				if (bin_count !== want.cnt)
					note_mismatch("bin_count", want.cnt, bin_count);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request driver. Inputs move on the falling edge; a request is taken
	// at the rising edge where start is high and busy low.
	// ------------------------------------------------------------------
	task automatic send_req(hist_req_t r, int gap, bit typed, hist_result_t want);
		hist_result_t pred;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		cmd         <= r.op;
		charge_a    <= r.qa;
		charge_b    <= r.qb;
		charge_time <= r.qt;
		read_bin    <= r.rb;
		do @(posedge clk); while (busy);
		pred = histogram_step(r);
		pending_results.push_back(typed ? want : pred);
	endtask

	// drop start and hold until every result is back and the block is idle
	task automatic drain_requests();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	// all seven registers, one per cycle, then the model copy follows
	task automatic write_config(hist_cfg_t c);
		logic [CFG_DATA_W-1:0] vals [7];
		vals[0] = CFG_DATA_W'(c.nbins);
		vals[1] = c.hmin;
		vals[2] = c.hmax;
		vals[3] = CFG_DATA_W'(c.lothr);
		vals[4] = CFG_DATA_W'(c.hithr);
		vals[5] = CFG_DATA_W'(c.sumlo);
		vals[6] = CFG_DATA_W'(c.sumhi);
		foreach (vals[i]) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= vals[i];
		end
		@(negedge clk);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	// ------------------------------------------------------------------
	// Stimulus shaping
	// ------------------------------------------------------------------
	// mostly short gaps, some long ones; burst phases never idle
	function automatic int pick_gap(bit burst);
		int p;
		p = $urandom_range(0, 99);
		if (burst || p < 40)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// first phases hit the register extremes, the rest are random
	function automatic hist_cfg_t phase_config(int ph);
		hist_cfg_t c;
		longint    a, b;
		int        p;
		case (ph)
			0: c = '{11'd1, -21'sd140000, 21'sd640000, 17'd0, 17'd65536, 15'd0, 15'd20000};
			1: c = '{11'd1024, 21'sd0, 21'sd100000, 17'd11250, 17'd30000, 15'd950, 15'd1090};
			// empty range with a bin count of zero
			2: c = '{11'd0, 21'sd640000, -21'sd140000, 17'd0, 17'd65536, 15'd0, 15'd20000};
			// bin count past the store, narrow range at the low end of time
			3: c = '{11'd2047, -21'sd140000, -21'sd100000, 17'd0, 17'd65536, 15'd100, 15'd15000};
			// closed gates: nothing can pass
			4: c = '{11'd7, 21'sd5000, 21'sd5000, 17'd65536, 17'd0, 15'd20000, 15'd0};
			5: c = '{11'd12, -21'sd1000, 21'sd90000, 17'd11000, 17'd20000, 15'd1000, 15'd3000};
			default: begin
				p = $urandom_range(0, 99);
				if (p < 50)
					c.nbins = 11'($urandom_range(1, 16));
				else if (p < 80)
					c.nbins = 11'($urandom_range(1, MAX_BINS_DEF));
				else if (p < 90)
					c.nbins = 11'd0;
				else
					c.nbins = 11'($urandom_range(MAX_BINS_DEF + 1, 2047));
				a = longint'($urandom_range(0, 780000)) - 140000;
				b = longint'($urandom_range(0, 780000)) - 140000;
				p = $urandom_range(0, 99);
				if (p < 30) begin
					b = a + longint'($urandom_range(1, 5000));
				end else if (p < 85) begin
					if (a > b) begin
						a = a ^ b;
						b = a ^ b;
						a = a ^ b;
					end
					if (a == b)
						b = a + 1;
				end else if (p < 92) begin
					a = longint'($urandom_range(0, 2097151)) - 1048576;
					b = longint'($urandom_range(0, 2097151)) - 1048576;
				end
				c.hmin = 21'(a);
				c.hmax = 21'(b);
				if ($urandom_range(0, 9) < 7) begin
					c.lothr = 17'($urandom_range(0, 20000));
					c.hithr = c.lothr + 17'($urandom_range(2, 45536));
				end else begin
					c.lothr = 17'($urandom);
					c.hithr = 17'($urandom);
				end
				if ($urandom_range(0, 9) < 8) begin
					c.sumlo = 15'($urandom_range(0, 8000));
					c.sumhi = c.sumlo + 15'($urandom_range(2, 3000));
				end else begin
					c.sumlo = 15'($urandom);
					c.sumhi = 15'($urandom);
				end
			end
		endcase
		return c;
	endfunction

	// mostly coincidences built to land in the energy window, plus raw noise
	function automatic hist_req_t random_req();
		hist_req_t r;
		int        p;
		longint    lo_k, hi_k, tgt, total, qa_max, qb_l, qt_l, qt_hi, span;
		r.op = CMD_EVENT;
		r.qa = 16'($urandom);
		r.qb = 16'($urandom);
		r.qt = 16'($urandom);
		r.rb = 11'($urandom);
		p = $urandom_range(0, 99);
		if (p < 1) begin
			r.op = CMD_CLEAR;
		end else if (p < 3) begin
			r.op = CMD_UNUSED;
		end else if (p < 15) begin
			r.op = CMD_READ;
			if ($urandom_range(0, 9) < 7)
				r.rb = 11'($urandom_range(0, bins_in_use() + 1));
		end else if (p >= 27) begin
			// pick an energy sum inside the window, split it over both channels
			lo_k = longint'(cur_cfg.sumlo) + 1;
			hi_k = longint'(cur_cfg.sumhi) - 1;
			if (hi_k > E_TOP_KEV)
				hi_k = E_TOP_KEV;
			if (lo_k <= hi_k) begin
				tgt    = lo_k + longint'($urandom_range(0, int'(hi_k - lo_k)));
				total  = tgt * KEV_SCALE + longint'($urandom_range(0, 65535)) + E_OFFSET;
				qa_max = total / GAIN_A;
				if (qa_max > 65535)
					qa_max = 65535;
				r.qa = 16'($urandom_range(0, int'(qa_max)));
				qb_l = (total - GAIN_A * longint'(r.qa)) / GAIN_B;
				if (qb_l > 65535)
					qb_l = 65535;
				r.qb = 16'(qb_l);
			end
			// timing charge aimed into the histogram range or between the thresholds
			span = longint'(cur_cfg.hmax) - longint'(cur_cfg.hmin);
			if ($urandom_range(0, 1) == 1 && span > 0) begin
				tgt  = longint'(cur_cfg.hmin) + longint'($urandom_range(0, int'(span - 1)));
				qt_l = TIME_ZERO + (tgt * TIME_DEN) / TIME_SCALE
					+ longint'($urandom_range(0, 2)) - 1;
			end else begin
				qt_l  = longint'(cur_cfg.lothr) + 1;
				qt_hi = longint'(cur_cfg.hithr) - 1;
				if (qt_hi > 65535)
					qt_hi = 65535;
				if (qt_l <= qt_hi)
					qt_l = qt_l + longint'($urandom_range(0, int'(qt_hi - qt_l)));
				else
					qt_l = longint'(r.qt);
			end
			if (qt_l < 0)
				qt_l = 0;
			if (qt_l > 65535)
				qt_l = 65535;
			r.qt = 16'(qt_l);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table, reset settings: 1024 bins over 0..640000, open
	// thresholds, window 950..1090 keV. Charges 4400/4522 sum to ~1000 keV.
	// ------------------------------------------------------------------
	dir_row_t directed_rows [16] = '{
		// empty store right after reset: underflow, overflow, past the store
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd0,    1'b1, 1'b0, 11'd0,    32'd0},
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd1025, 1'b1, 1'b0, 11'd1025, 32'd0},
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd2047, 1'b1, 1'b0, 11'd2047, 32'd0},
		// unused code does nothing
		'{CMD_UNUSED, 16'hFFFF,  16'hFFFF,  16'hFFFF,  11'h7FF,  1'b1, 1'b0, 11'd0,    32'd0},
		// energy below and above the window
		'{CMD_EVENT,  16'd0,     16'd0,     16'd0,     11'd0,    1'b1, 1'b0, 11'd0,    32'd0},
		'{CMD_EVENT,  16'hFFFF,  16'hFFFF,  16'h8000,  11'd0,    1'b1, 1'b0, 11'd0,    32'd0},
		// timing charge not above the lower threshold
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'd0,     11'd0,    1'b1, 1'b0, 11'd0,    32'd0},
		// just under the range, first bin, top of the timing charge
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'd11249, 11'd0,    1'b0, 1'b0, 11'd0,    32'd0},
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'd11250, 11'd0,    1'b0, 1'b0, 11'd0,    32'd0},
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'hFFFF,  11'd0,    1'b0, 1'b0, 11'd0,    32'd0},
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'd11250, 11'h7FF,  1'b0, 1'b0, 11'd0,    32'd0},
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd1,    1'b0, 1'b0, 11'd0,    32'd0},
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd0,    1'b0, 1'b0, 11'd0,    32'd0},
		// clear, then the bin reads back empty
		'{CMD_CLEAR,  16'hFFFF,  16'hFFFF,  16'hFFFF,  11'h7FF,  1'b1, 1'b0, 11'd0,    32'd0},
		'{CMD_READ,   16'd0,     16'd0,     16'd0,     11'd1,    1'b1, 1'b0, 11'd1,    32'd0},
		'{CMD_EVENT,  16'd4400,  16'd4522,  16'hFFFF,  11'd0,    1'b0, 1'b0, 11'd0,    32'd0}
	};

	initial begin : stimulus
		hist_req_t    r;
		hist_result_t want;
		cur_cfg = '{RST_NUM_BINS, RST_HIST_MIN, RST_HIST_MAX, RST_LOW_THR, RST_HIGH_THR,
			RST_SUM_LOW, RST_SUM_HIGH};
		foreach (bin_counts[i])
			bin_counts[i] = '0;
		want = '{acc: 1'b0, idx: '0, cnt: '0};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// the clearing sweep after reset keeps busy high; send_req waits it out
		foreach (directed_rows[i]) begin
			r    = '{directed_rows[i].op, directed_rows[i].qa, directed_rows[i].qb,
				directed_rows[i].qt, directed_rows[i].rb};
			want = '{directed_rows[i].w_acc, directed_rows[i].w_idx, directed_rows[i].w_cnt};
			send_req(r, pick_gap(1'b0), directed_rows[i].typed, want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_requests();
			write_config(phase_config(ph));
			for (int k = 0; k < REQS_PER_PHASE; k++) begin
				// now and then let the pipeline run dry before the next request
				if ($urandom_range(0, 99) < 2)
					drain_requests();
				send_req(random_req(), pick_gap(ph % 3 == 2), 1'b0, want);
			end
		end

		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#40_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
